/* rtl/stb_pkg.sv */
// ----------------------------------------------------------------------------
// stb_pkg: shared types and codes for the software timer bank
// Request and response item layouts, command and result codes, the
// sequencer state type and the arithmetic unit's result bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package stb_pkg;

	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_STOP  = 2'd2;

	localparam logic [2:0] K_TIMEOUT       = 3'd0;
	localparam logic [2:0] K_DONE          = 3'd1;
	localparam logic [2:0] K_START_OK      = 3'd2;
	localparam logic [2:0] K_START_ACTIVE  = 3'd3;
	localparam logic [2:0] K_START_PENDING = 3'd4;
	localparam logic [2:0] K_STOP_OK       = 3'd5;
	localparam logic [2:0] K_STOP_REJ      = 3'd6;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [3:0]  timer_id;
		logic [15:0] elapsed_ms;
		logic [30:0] start_remaining;
		logic [30:0] period_ms;
		logic        oneshot;
	} req_item_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [3:0] event_id;
		logic       last;
	} rsp_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic        timeout;
		logic [31:0] remaining;
	} alu_res_t;

endpackage

`default_nettype wire

/* rtl/stb_alu.sv */
// ----------------------------------------------------------------------------
// stb_alu: remaining-time update unit
// Subtracts the elapsed time with saturation at the signed 32-bit lower
// bound and, on expiry, adds the reload interval once.
// ----------------------------------------------------------------------------
`default_nettype none

module stb_alu (
	input  wire logic [31:0]       remaining,
	input  wire logic [15:0]       elapsed,
	input  wire logic [30:0]       period,
	output stb_pkg::alu_res_t      res
);
	import stb_pkg::*;

	logic [32:0] diff;
	logic [31:0] sat;

	always_comb begin
		diff = {remaining[31], remaining} - {17'd0, elapsed};
		// Below -2^31 the sign bit and the bit under it disagree.
		if (diff[32] && !diff[31]) begin
			sat = 32'h8000_0000;
		end else begin
			sat = diff[31:0];
		end
		res.timeout = sat[31];
		if (sat[31]) begin
			res.remaining = sat + {1'b0, period};
		end else begin
			res.remaining = sat;
		end
	end

endmodule

`default_nettype wire

/* rtl/software_timer_bank.sv */
// ----------------------------------------------------------------------------
// software_timer_bank: table of periodic and one-shot timers
// A small sequencer walks the timer table through one shared update unit.
// ----------------------------------------------------------------------------
// Usage
//   Requests arrive on req (valid/stall), results leave on rsp (valid/stall).
//   A start or stop request yields one result, registered in the cycle after
//   the transaction; the block then takes a new request at once.
//   A tick request walks all NUM_TIMERS entries, one per cycle while the
//   receiver takes its timeouts, through the single update unit fed by the
//   registered table read, and then ends in a done state that does the
//   clean-up and sends the tick done result. It emits one timeout per expired
//   entry and then the tick done result marked last.
//   Requests are stalled while a tick is in progress and while a finished
//   result waits on a stalled receiver. A stalled receiver holds the scan
//   on the entry whose timeout cannot yet be delivered.
//   Reset empties the table at once: valid and removal marks live in
//   flip-flops, so there is no clearing pass. Stored times are only used
//   for valid entries.
// ----------------------------------------------------------------------------
`default_nettype none

module software_timer_bank #(
	parameter int NUM_TIMERS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_stall,
	input  wire stb_pkg::req_item_t  req,
	output logic                     rsp_valid,
	input  wire logic                rsp_stall,
	output stb_pkg::rsp_item_t       rsp
);
	import stb_pkg::*;

	localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int CW = $clog2(NUM_TIMERS + 1);

	// Timer table storage.
	logic [31:0] rem_mem [NUM_TIMERS];
	logic [30:0] per_mem [NUM_TIMERS];
	logic        os_mem  [NUM_TIMERS];

	logic [NUM_TIMERS-1:0] valid_q;
	logic [NUM_TIMERS-1:0] pending_q;

	state_t state_q, state_d;

	logic [CW-1:0] idx_q;
	logic [15:0]   elapsed_q;
	logic          p_valid_s1;
	logic [IW-1:0] p_idx_s1;
	logic [31:0]   rem_s1;
	logic [30:0]   per_s1;
	logic          os_s1;

	logic      rsp_valid_q;
	rsp_item_t rsp_q;

	alu_res_t alu;

	logic          take, rsp_free;
	logic [IW-1:0] sid, rd_addr, idx_a;
	logic          sid_in_range, idx_in_range;
	logic          sid_valid, sid_pending;
	logic          emit, scan_start, start_wr, stop_set, proc, issue, finish, can_go, need;
	rsp_item_t     emit_item;

	stb_alu u_alu (
		.remaining (rem_s1),
		.elapsed   (elapsed_q),
		.period    (per_s1),
		.res       (alu)
	);

	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = !(state_q == ST_IDLE && rsp_free);
	assign take      = req_valid && !req_stall;

	assign sid          = IW'(req.timer_id);
	assign sid_in_range = {3'd0, req.timer_id} < NUM_TIMERS;
	assign sid_valid    = valid_q[sid];
	assign sid_pending  = pending_q[sid];

	assign idx_in_range = idx_q < NUM_TIMERS;
	assign idx_a        = idx_in_range ? idx_q[IW-1:0] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		emit       = 1'b0;
		emit_item  = '0;
		scan_start = 1'b0;
		start_wr   = 1'b0;
		stop_set   = 1'b0;
		proc       = 1'b0;
		issue      = 1'b0;
		finish     = 1'b0;
		need       = p_valid_s1 && alu.timeout;
		can_go     = !need || rsp_free;
		case (state_q)
			ST_IDLE: begin
				if (take) begin
					emit_item.event_id = req.timer_id;
					emit_item.last     = 1'b1;
					case (req.cmd)
						CMD_TICK: begin
							scan_start = 1'b1;
							state_d    = ST_SCAN;
						end
						CMD_START: begin
							emit = 1'b1;
							if (!sid_in_range || (sid_valid && !sid_pending)) begin
								emit_item.kind = K_START_ACTIVE;
							end else if (sid_valid) begin
								emit_item.kind = K_START_PENDING;
							end else begin
								start_wr       = 1'b1;
								emit_item.kind = K_START_OK;
							end
						end
						CMD_STOP: begin
							emit = 1'b1;
							if (sid_in_range && sid_valid && !sid_pending) begin
								stop_set       = 1'b1;
								emit_item.kind = K_STOP_OK;
							end else begin
								emit_item.kind = K_STOP_REJ;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_SCAN: begin
				if (can_go) begin
					proc               = p_valid_s1;
					emit               = need;
					emit_item.kind     = K_TIMEOUT;
					emit_item.event_id = 4'(p_idx_s1);
					emit_item.last     = 1'b0;
					issue              = idx_in_range;
					if (!idx_in_range) begin
						state_d = ST_DONE;
					end
				end
			end
			ST_DONE: begin
				if (rsp_free) begin
					emit           = 1'b1;
					emit_item.kind = K_DONE;
					emit_item.last = 1'b1;
					finish         = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// While a timeout is held back, the same entry is read again.
	assign rd_addr = can_go ? idx_a : p_idx_s1;

	always_ff @(posedge clk) begin
		rem_s1 <= rem_mem[rd_addr];
		per_s1 <= per_mem[rd_addr];
		os_s1  <= os_mem[rd_addr];
		if (start_wr) begin
			rem_mem[sid] <= {1'b0, req.start_remaining};
			per_mem[sid] <= req.period_ms;
			os_mem[sid]  <= req.oneshot;
		end else if (proc) begin
			rem_mem[p_idx_s1] <= alu.remaining;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			pending_q  <= '0;
			idx_q      <= '0;
			p_valid_s1 <= 1'b0;
			p_idx_s1   <= '0;
		end else begin
			if (scan_start) begin
				idx_q      <= '0;
				p_valid_s1 <= 1'b0;
			end else if (state_q == ST_SCAN && can_go) begin
				p_valid_s1 <= issue && valid_q[idx_a];
				p_idx_s1   <= idx_a;
				if (issue) begin
					idx_q <= idx_q + CW'(1);
				end
			end
			if (start_wr) begin
				valid_q[sid]   <= 1'b1;
				pending_q[sid] <= 1'b0;
			end
			if (stop_set) begin
				pending_q[sid] <= 1'b1;
			end
			if (proc && alu.timeout && os_s1) begin
				pending_q[p_idx_s1] <= 1'b1;
			end
			if (finish) begin
				valid_q   <= valid_q & ~pending_q;
				pending_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (scan_start) begin
			elapsed_q <= req.elapsed_ms;
		end
		if (emit) begin
			rsp_q <= emit_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// A tick transaction always starts a scan.
	a_tick_scans: assert property (@(posedge clk) disable iff (!arst_n)
		(take && req.cmd == CMD_TICK) |=> state_q == ST_SCAN)
		else $error("tick did not start a scan");

	// Removal marks only ever sit on valid entries.
	a_pending_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(pending_q & ~valid_q) == '0)
		else $error("removal mark on an empty entry");

	// The end of a tick leaves no removal marks behind.
	a_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> pending_q == '0)
		else $error("removal marks survived the end of a tick");

	// The entry in the update stage is a valid one.
	a_stage_valid: assert property (@(posedge clk) disable iff (!arst_n)
		p_valid_s1 |-> valid_q[p_idx_s1])
		else $error("update stage holds an empty entry");

	// A timeout is never the final result of a tick.
	a_timeout_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.kind == K_TIMEOUT) |-> !rsp_q.last)
		else $error("timeout result marked last");

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: testbench for the software timer bank
// A queue-fed driver offers start, stop, tick and unused-command requests
// with random gaps. A monitor accepts results under random back-pressure. Each accepted
// request runs through a timer-table predictor that queues the results it
// should cause, and every accepted result is checked against the oldest one.
// A directed opening is followed by random traffic, one long receiver
// hold-off, a full drain, and a tick that fires all sixteen timers at once.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	import stb_pkg::*;

	localparam int             TIMERS       = 16;
	localparam logic [1:0]     CMD_UNUSED   = 2'd3;
	localparam longint         REMAIN_FLOOR = -64'sd2147483648;
	localparam int             SINK_HOLDOFF = 250;
	localparam logic [30:0]    TIME_MAX     = 31'h7FFF_FFFF;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	req_item_t req       = '0;
	logic      rsp_stall = 1'b0;
	logic      req_stall;
	logic      rsp_valid;
	rsp_item_t rsp;

	// Mirror of the timer table, updated as each request transaction lands.
	logic        tbl_valid   [TIMERS] = '{default: 1'b0};
	logic        tbl_dying   [TIMERS] = '{default: 1'b0};
	logic        tbl_oneshot [TIMERS] = '{default: 1'b0};
	logic [31:0] tbl_left    [TIMERS] = '{default: '0};
	logic [30:0] tbl_period  [TIMERS] = '{default: '0};

	req_item_t   pending_reqs[$];
	rsp_item_t   awaited_events[$];

	bit          calm        = 1'b0;
	bit          holdoff_req = 1'b0;
	bit          holdoff_done;
	int          holdoff_left;
	int unsigned send_gap;
	int unsigned sink_gap;
	int          mismatches  = 0;

	software_timer_bank #(
		.NUM_TIMERS(TIMERS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int unsigned idle_draw();
		if (calm || $urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(0, 15);
	endfunction

	function automatic void queue_result(input logic [2:0] kind, input int id,
					     input logic last);
		rsp_item_t ev;
		ev.kind     = kind;
		ev.event_id = id[3:0];
		ev.last     = last;
		awaited_events.push_back(ev);
	endfunction

	function automatic void timer_table_step(input req_item_t it);
		longint left;
		int     id;
		id = int'(it.timer_id);
		if (it.cmd == CMD_TICK) begin
			for (int i = 0; i < TIMERS; i++) begin
				if (!tbl_valid[i])
					continue;
				left = longint'($signed(tbl_left[i])) - longint'(it.elapsed_ms);
				if (left < REMAIN_FLOOR)
					left = REMAIN_FLOOR;
				if (left < 0) begin
					queue_result(K_TIMEOUT, i, 1'b0);
					if (tbl_oneshot[i])
						tbl_dying[i] = 1'b1;
					left = left + longint'(tbl_period[i]);
				end
				tbl_left[i] = left[31:0];
			end
			for (int i = 0; i < TIMERS; i++) begin
				if (tbl_dying[i]) begin
					tbl_valid[i] = 1'b0;
					tbl_dying[i] = 1'b0;
				end
			end
			queue_result(K_DONE, 0, 1'b1);
		end else if (it.cmd == CMD_START) begin
			if (id >= TIMERS || (tbl_valid[id] && !tbl_dying[id])) begin
				queue_result(K_START_ACTIVE, id, 1'b1);
			end else if (tbl_valid[id]) begin
				queue_result(K_START_PENDING, id, 1'b1);
			end else begin
				tbl_valid[id]   = 1'b1;
				tbl_dying[id]   = 1'b0;
				tbl_left[id]    = {1'b0, it.start_remaining};
				tbl_period[id]  = it.period_ms;
				tbl_oneshot[id] = it.oneshot;
				queue_result(K_START_OK, id, 1'b1);
			end
		end else if (it.cmd == CMD_STOP) begin
			if (id < TIMERS && tbl_valid[id] && !tbl_dying[id]) begin
				tbl_dying[id] = 1'b1;
				queue_result(K_STOP_OK, id, 1'b1);
			end else begin
				queue_result(K_STOP_REJ, id, 1'b1);
			end
		end
	endfunction

	// Request driver: one transaction per item, then its drawn gap.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req       <= '0;
			send_gap   = 0;
		end else if (!req_valid || !req_stall) begin
			if (req_valid)
				timer_table_step(req);
			if (send_gap != 0) begin
				send_gap   = send_gap - 1;
				req_valid <= 1'b0;
			end else if (pending_reqs.size() != 0) begin
				req       <= pending_reqs.pop_front();
				req_valid <= 1'b1;
				send_gap   = idle_draw();
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Result monitor and back-pressure.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall   <= 1'b0;
			sink_gap     = 0;
			holdoff_left = 0;
			holdoff_done = 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (awaited_events.size() == 0) begin
					$error("result with nothing awaited: kind %0d id %0d last %0d",
					       rsp.kind, rsp.event_id, rsp.last);
					mismatches++;
				end else begin
					if (rsp.kind !== awaited_events[0].kind) begin
						$error("kind: expected %0d, got %0d",
						       awaited_events[0].kind, rsp.kind);
						mismatches++;
					end
					if (rsp.event_id !== awaited_events[0].event_id) begin
						$error("event_id: expected %0d, got %0d",
						       awaited_events[0].event_id, rsp.event_id);
						mismatches++;
					end
					if (rsp.last !== awaited_events[0].last) begin
						$error("last: expected %0d, got %0d",
						       awaited_events[0].last, rsp.last);
						mismatches++;
					end
					void'(awaited_events.pop_front());
				end
				sink_gap = idle_draw();
			end
			if (holdoff_req && !holdoff_done) begin
				holdoff_done = 1'b1;
				holdoff_left = SINK_HOLDOFF;
			end
			if (holdoff_left != 0) begin
				holdoff_left = holdoff_left - 1;
				rsp_stall   <= 1'b1;
			end else if (sink_gap != 0) begin
				sink_gap   = sink_gap - 1;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	function automatic req_item_t mk_req(input logic [1:0] cmd, input int id,
					     input logic [15:0] elapsed,
					     input logic [30:0] remaining,
					     input logic [30:0] period, input logic oneshot);
		req_item_t r;
		r.cmd             = cmd;
		r.timer_id        = id[3:0];
		r.elapsed_ms      = elapsed;
		r.start_remaining = remaining;
		r.period_ms       = period;
		r.oneshot         = oneshot;
		return r;
	endfunction

	// Mostly short times so that timers expire often; now and then the full
	// field width so that every bit is exercised.
	task automatic queue_random(input int count);
		req_item_t   r;
		int unsigned pick;
		int          done_cnt;
		done_cnt = 0;
		while (done_cnt < count) begin
			r.timer_id        = 4'($urandom_range(0, 15));
			r.oneshot         = 1'($urandom_range(0, 1));
			r.start_remaining = ($urandom_range(0, 3) == 0) ? 31'($urandom)
									: 31'($urandom_range(0, 3000));
			r.period_ms       = ($urandom_range(0, 3) == 0) ? 31'($urandom)
									: 31'($urandom_range(0, 3000));
			r.elapsed_ms      = ($urandom_range(0, 3) == 0) ? 16'($urandom)
									: 16'($urandom_range(0, 1500));
			pick = $urandom_range(0, 99);
			if (pick < 40)
				r.cmd = CMD_START;
			else if (pick < 65)
				r.cmd = CMD_STOP;
			else if (pick < 96)
				r.cmd = CMD_TICK;
			else
				r.cmd = CMD_UNUSED;
			pending_reqs.push_back(r);
			if (r.cmd != CMD_UNUSED)
				done_cnt++;
		end
	endtask

	task automatic wait_quiet();
		while (pending_reqs.size() != 0 || req_valid || awaited_events.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed opening: empty tick, each start and stop outcome, the
		// unknown command, field extremes and removal at the end of a tick.
		pending_reqs.push_back(mk_req(CMD_TICK,   0, 16'h0000, 31'd0, 31'd0, 1'b0));
		pending_reqs.push_back(mk_req(CMD_STOP,   0, 16'h0000, 31'd0, 31'd0, 1'b0));
		pending_reqs.push_back(mk_req(CMD_START,  0, 16'h0000, 31'd0, 31'd0, 1'b1));
		pending_reqs.push_back(mk_req(CMD_START,  0, 16'h0000, 31'd5, 31'd5, 1'b0));
		pending_reqs.push_back(mk_req(CMD_START, 15, 16'hFFFF, TIME_MAX, TIME_MAX, 1'b0));
		pending_reqs.push_back(mk_req(CMD_START,  3, 16'h0000, 31'd10, 31'd100, 1'b0));
		pending_reqs.push_back(mk_req(CMD_STOP,   3, 16'h0000, 31'd0, 31'd0, 1'b0));
		pending_reqs.push_back(mk_req(CMD_START,  3, 16'h0000, 31'd20, 31'd20, 1'b1));
		pending_reqs.push_back(mk_req(CMD_STOP,   3, 16'h0000, 31'd0, 31'd0, 1'b0));
		pending_reqs.push_back(mk_req(CMD_UNUSED, 3, 16'hFFFF, TIME_MAX, TIME_MAX, 1'b1));
		pending_reqs.push_back(mk_req(CMD_TICK,   0, 16'h0000, 31'd0, 31'd0, 1'b0));
		pending_reqs.push_back(mk_req(CMD_TICK,   0, 16'h0001, 31'd0, 31'd0, 1'b0));
		pending_reqs.push_back(mk_req(CMD_START,  7, 16'h0000, 31'd5, 31'd7, 1'b0));
		pending_reqs.push_back(mk_req(CMD_TICK,   0, 16'hFFFF, 31'd0, 31'd0, 1'b0));
		pending_reqs.push_back(mk_req(CMD_START,  7, 16'h0000, 31'd1, 31'd1, 1'b0));
		pending_reqs.push_back(mk_req(CMD_TICK,   0, 16'hFFFF, 31'd0, 31'd0, 1'b0));
		pending_reqs.push_back(mk_req(CMD_STOP,  15, 16'h0000, 31'd0, 31'd0, 1'b0));
		pending_reqs.push_back(mk_req(CMD_STOP,   7, 16'h0000, 31'd0, 31'd0, 1'b0));
		pending_reqs.push_back(mk_req(CMD_TICK,   0, 16'h0001, 31'd0, 31'd0, 1'b0));
		pending_reqs.push_back(mk_req(CMD_START, 15, 16'h0000, 31'd0, TIME_MAX, 1'b1));
		pending_reqs.push_back(mk_req(CMD_TICK,   0, 16'h0001, 31'd0, 31'd0, 1'b0));
		pending_reqs.push_back(mk_req(CMD_STOP,  15, 16'h0000, 31'd0, 31'd0, 1'b0));
		pending_reqs.push_back(mk_req(CMD_TICK,   0, 16'h0000, 31'd0, 31'd0, 1'b0));
		wait_quiet();

		// Random traffic. The receiver holds off for a long stretch during the
		// first batch so that the block fills and stalls its input.
		queue_random(30);
		holdoff_req = 1'b1;
		wait_quiet();
		calm = 1'b1;
		queue_random(15);
		while (pending_reqs.size() != 0)
			@(negedge clk);
		calm = 1'b0;
		queue_random(25);
		wait_quiet();

		// Empty the table, fire all sixteen timers in one tick, then stop the
		// one periodic timer left and tick once more.
		calm = 1'b1;
		for (int i = 0; i < TIMERS; i++)
			pending_reqs.push_back(mk_req(CMD_STOP, i, 16'h0000, 31'd0, 31'd0, 1'b0));
		pending_reqs.push_back(mk_req(CMD_TICK, 0, 16'hFFFF, 31'd0, 31'd0, 1'b0));
		for (int i = 0; i < TIMERS; i++)
			pending_reqs.push_back(mk_req(CMD_START, i, 16'h0000, 31'd0, 31'd0,
						      (i == 9) ? 1'b0 : 1'b1));
		pending_reqs.push_back(mk_req(CMD_TICK, 0, 16'h0001, 31'd0, 31'd0, 1'b0));
		pending_reqs.push_back(mk_req(CMD_STOP, 9, 16'h0000, 31'd0, 31'd0, 1'b0));
		pending_reqs.push_back(mk_req(CMD_TICK, 0, 16'hFFFF, 31'd0, 31'd0, 1'b0));
		wait_quiet();

		repeat (4 * TIMERS) @(posedge clk);
		if (mismatches == 0)
			$display("software_timer_bank test passed");
		else
			$display("software_timer_bank test failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("software_timer_bank test failed");
		$finish;
	end

endmodule

`default_nettype wire
